FILE: design/perd_pkg.sv
// Package for the point extension block: widths, CORDIC constants, atan table.
// Used by every module of the block; depends on nothing.
`default_nettype none
package perd_pkg;
   localparam int COORD_WIDTH_DEF   = 32;
   localparam int ANGLE_WIDTH_DEF   = 16;
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int DIFF_W  = 34;   // coordinate difference, one bit of headroom
   localparam int VEC_W   = 44;   // normalized vectoring datapath
   localparam int ROT_W   = 34;   // Q4.30 rotation datapath
   localparam int LEN_W   = 32;
   localparam logic signed [ROT_W-1:0] GAIN_Q30  = 34'sd652032874;
   localparam logic signed [ROT_W-1:0] SMALL_Q30 = 34'sd10737418;
   localparam logic [31:0] HALF_TURN = 32'h8000_0000;
   localparam int QUEUE_DEPTH = 4;

   function automatic logic [31:0] atan_entry(input int i);
      logic [31:0] t [24];
      t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
            32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
            32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
            32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
            32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
      return t[i];
   endfunction

   // Round a binary angle to the nearest multiple of 2^(32-aw).
   function automatic logic [31:0] quant_angle(input logic [31:0] a, input int aw);
      logic [31:0] half;
      logic [31:0] mask;
      half = 32'd1 << (31 - aw);
      mask = ~((32'd1 << (32 - aw)) - 32'd1);
      return (a + half) & mask;
   endfunction

   typedef struct packed {
      logic               moved;
      logic signed [31:0] ex;
      logic signed [31:0] ey;
      logic signed [31:0] ez;
      logic signed [31:0] len;
   } item_type;
endpackage
`default_nettype wire

FILE: design/perd_front.sv
// Front part: accept a point pair, classify equal points, find direction angle.
// Pipelined vectoring CORDIC, one stage per iteration. Depends on perd_pkg.
`default_nettype none
module perd_front
   import perd_pkg::*;
#(
   parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire logic signed [31:0] sx, sy, sz, ex, ey, ez, len,
   input  wire logic signed [15:0] off,
   output logic                    out_valid,
   output item_type                out_item,
   output logic [31:0]             out_theta
);
   localparam int N = CORDIC_STAGES;
   localparam int NW = $clog2(VEC_W + 1);

   // stage 0: differences and equality
   logic               v0_ff;
   item_type           i0_ff;
   logic signed [DIFF_W-1:0] dx0_ff, dy0_ff;
   logic [31:0]        off0_ff;
   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else v0_ff <= in_valid;
      i0_ff.moved <= !(sx == ex && sy == ey && sz == ez);
      i0_ff.ex <= ex; i0_ff.ey <= ey; i0_ff.ez <= ez; i0_ff.len <= len;
      dx0_ff  <= DIFF_W'(ex) - DIFF_W'(sx);
      dy0_ff  <= DIFF_W'(ey) - DIFF_W'(sy);
      off0_ff <= quant_angle({off, 16'd0}, ANGLE_WIDTH);
   end

   // stage 1: magnitude OR for normalization
   logic               v1_ff;
   item_type           i1_ff;
   logic signed [DIFF_W-1:0] dx1_ff, dy1_ff;
   logic [DIFF_W-1:0]  m1_ff;
   logic [31:0]        off1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= v0_ff;
      i1_ff <= i0_ff; dx1_ff <= dx0_ff; dy1_ff <= dy0_ff; off1_ff <= off0_ff;
      m1_ff <= (dx0_ff < 0 ? DIFF_W'(-dx0_ff) : DIFF_W'(dx0_ff))
             | (dy0_ff < 0 ? DIFF_W'(-dy0_ff) : DIFF_W'(dy0_ff));
   end

   // normalize so the magnitude OR reaches bit 39, then fold into right half plane
   logic [NW-1:0] sh;
   always_comb begin
      sh = '0;
      for (int b = 0; b < DIFF_W; b++)
         if (m1_ff[b]) sh = NW'(39 - b);
   end

   logic               vv_ff  [N+1];
   item_type           vi_ff  [N+1];
   logic signed [VEC_W-1:0] vx_ff [N+1], vy_ff [N+1];
   logic [31:0]        vz_ff  [N+1];
   logic [31:0]        voff_ff[N+1];
   logic               vzero_ff[N+1];

   always_ff @(posedge clock) begin
      logic signed [VEC_W-1:0] x, y;
      x = VEC_W'(dx1_ff) <<< sh;
      y = VEC_W'(dy1_ff) <<< sh;
      if (reset) vv_ff[0] <= 1'b0;
      else vv_ff[0] <= v1_ff;
      vi_ff[0] <= i1_ff; voff_ff[0] <= off1_ff;
      vzero_ff[0] <= (m1_ff == '0);
      if (x < 0) begin
         vx_ff[0] <= -x; vy_ff[0] <= -y; vz_ff[0] <= HALF_TURN;
      end else begin
         vx_ff[0] <= x; vy_ff[0] <= y; vz_ff[0] <= '0;
      end
   end

   // vectoring iterations, one per stage
   for (genvar g = 0; g < N; g++) begin : g_vec
      always_ff @(posedge clock) begin
         if (reset) vv_ff[g+1] <= 1'b0;
         else vv_ff[g+1] <= vv_ff[g];
         vi_ff[g+1] <= vi_ff[g]; voff_ff[g+1] <= voff_ff[g];
         vzero_ff[g+1] <= vzero_ff[g];
         if (vy_ff[g] > 0) begin
            vx_ff[g+1] <= vx_ff[g] + (vy_ff[g] >>> g);
            vy_ff[g+1] <= vy_ff[g] - (vx_ff[g] >>> g);
            vz_ff[g+1] <= vz_ff[g] + atan_entry(g);
         end else begin
            vx_ff[g+1] <= vx_ff[g] - (vy_ff[g] >>> g);
            vy_ff[g+1] <= vy_ff[g] + (vx_ff[g] >>> g);
            vz_ff[g+1] <= vz_ff[g] - atan_entry(g);
         end
      end
   end

   // combine direction and offset
   always_ff @(posedge clock) begin
      logic [31:0] d;
      d = vzero_ff[N] ? 32'd0 : quant_angle(vz_ff[N], ANGLE_WIDTH);
      if (reset) out_valid <= 1'b0;
      else out_valid <= vv_ff[N];
      out_item  <= vi_ff[N];
      out_theta <= d + voff_ff[N];
   end
endmodule
`default_nettype wire

FILE: design/perd_queue.sv
// Short FIFO between front and back parts.
// Holds classified items with their angle. Depends on perd_pkg.
`default_nettype none
module perd_queue
   import perd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        wr_valid,
   input  wire item_type    wr_item,
   input  wire logic [31:0] wr_theta,
   output logic             rd_valid,
   output item_type         rd_item,
   output logic [31:0]      rd_theta
);
   localparam int AW = $clog2(QUEUE_DEPTH);
   item_type    item_ff  [QUEUE_DEPTH];
   logic [31:0] theta_ff [QUEUE_DEPTH];
   logic [AW:0] wp_ff, rp_ff;

   // the back part never stalls, so drain every cycle the queue holds data
   assign rd_valid = (wp_ff != rp_ff);
   assign rd_item  = item_ff[rp_ff[AW-1:0]];
   assign rd_theta = theta_ff[rp_ff[AW-1:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0;
      end else begin
         if (wr_valid) wp_ff <= wp_ff + 1'b1;
         if (rd_valid) rp_ff <= rp_ff + 1'b1;
      end
      if (wr_valid) begin
         item_ff[wp_ff[AW-1:0]]  <= wr_item;
         theta_ff[wp_ff[AW-1:0]] <= wr_theta;
      end
   end
endmodule
`default_nettype wire

FILE: design/perd_back.sv
// Back part: rotation CORDIC for cos/sin, multiply by length, saturating add.
// Pipelined, one item per cycle. Depends on perd_pkg.
`default_nettype none
module perd_back
   import perd_pkg::*;
#(
   parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   input  wire item_type    in_item,
   input  wire logic [31:0] in_theta,
   output logic             out_valid,
   output logic signed [COORD_WIDTH-1:0] new_x, new_y, new_z,
   output logic             moved
);
   localparam int N = CORDIC_STAGES;
   localparam int PW = LEN_W + ROT_W;

   logic               rv_ff [N+1];
   item_type           ri_ff [N+1];
   logic               rneg_ff[N+1];
   logic signed [ROT_W-1:0] rx_ff [N+1], ry_ff [N+1];
   logic signed [32:0] rz_ff [N+1];

   // fold the angle into the right half plane
   always_ff @(posedge clock) begin
      logic neg;
      logic [31:0] t;
      neg = (in_theta[31:30] == 2'd1) || (in_theta[31:30] == 2'd2);
      t = neg ? in_theta - HALF_TURN : in_theta;
      if (reset) rv_ff[0] <= 1'b0;
      else rv_ff[0] <= in_valid;
      ri_ff[0] <= in_item; rneg_ff[0] <= neg;
      rx_ff[0] <= GAIN_Q30; ry_ff[0] <= '0;
      rz_ff[0] <= 33'(signed'(t));
   end

   for (genvar g = 0; g < N; g++) begin : g_rot
      always_ff @(posedge clock) begin
         if (reset) rv_ff[g+1] <= 1'b0;
         else rv_ff[g+1] <= rv_ff[g];
         ri_ff[g+1] <= ri_ff[g]; rneg_ff[g+1] <= rneg_ff[g];
         if (rz_ff[g] >= 0) begin
            rx_ff[g+1] <= rx_ff[g] - (ry_ff[g] >>> g);
            ry_ff[g+1] <= ry_ff[g] + (rx_ff[g] >>> g);
            rz_ff[g+1] <= rz_ff[g] - 33'(atan_entry(g));
         end else begin
            rx_ff[g+1] <= rx_ff[g] + (ry_ff[g] >>> g);
            ry_ff[g+1] <= ry_ff[g] - (rx_ff[g] >>> g);
            rz_ff[g+1] <= rz_ff[g] + 33'(atan_entry(g));
         end
      end
   end

   // restore sign
   logic               c_v_ff;
   item_type           c_i_ff;
   logic signed [ROT_W-1:0] c_ff, s_ff;
   always_ff @(posedge clock) begin
      if (reset) c_v_ff <= 1'b0;
      else c_v_ff <= rv_ff[N];
      c_i_ff <= ri_ff[N];
      c_ff <= rneg_ff[N] ? -rx_ff[N] : rx_ff[N];
      s_ff <= rneg_ff[N] ? -ry_ff[N] : ry_ff[N];
   end

   // multiply by length, flag small components
   logic               m_v_ff;
   item_type           m_i_ff;
   logic signed [PW-1:0] px_ff, py_ff;
   logic               mvx_ff, mvy_ff;
   always_ff @(posedge clock) begin
      if (reset) m_v_ff <= 1'b0;
      else m_v_ff <= c_v_ff;
      m_i_ff <= c_i_ff;
      px_ff  <= PW'(c_i_ff.len) * PW'(c_ff);
      py_ff  <= PW'(c_i_ff.len) * PW'(s_ff);
      mvx_ff <= c_i_ff.moved && (c_ff > SMALL_Q30 || c_ff < -SMALL_Q30);
      mvy_ff <= c_i_ff.moved && (s_ff > SMALL_Q30 || s_ff < -SMALL_Q30);
   end

   // round, add and saturate
   localparam int SW = PW + 2;
   localparam logic signed [SW-1:0] HI = SW'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
   localparam logic signed [SW-1:0] LO = -HI - SW'(1);
   function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [SW-1:0] v);
      if (v > HI) return COORD_WIDTH'(HI);
      if (v < LO) return COORD_WIDTH'(LO);
      return COORD_WIDTH'(v);
   endfunction

   always_ff @(posedge clock) begin
      logic signed [SW-1:0] dx, dy, bx, by;
      dx = (SW'(px_ff) + (SW'(1) <<< 29)) >>> 30;
      dy = (SW'(py_ff) + (SW'(1) <<< 29)) >>> 30;
      bx = SW'(m_i_ff.ex) + (mvx_ff ? dx : SW'(0));
      by = SW'(m_i_ff.ey) + (mvy_ff ? dy : SW'(0));
      if (reset) out_valid <= 1'b0;
      else out_valid <= m_v_ff;
      new_x <= m_i_ff.moved ? sat(bx) : COORD_WIDTH'(m_i_ff.ex);
      new_y <= m_i_ff.moved ? sat(by) : COORD_WIDTH'(m_i_ff.ey);
      new_z <= COORD_WIDTH'(m_i_ff.ez);
      moved <= m_i_ff.moved;
   end
endmodule
`default_nettype wire

FILE: design/point_extend_along_rotated_direction.sv
// Point extension along a rotated direction: takes one item every clock cycle
// (busy is never raised) and passes it through two pipelined CORDIC units
// (vectoring in the front, rotation in the back), a short queue between them,
// and the multiply and saturate stages.
// The result strobe cannot be held off; every result appears for one cycle.
// Top level; depends on perd_pkg, perd_front, perd_queue, perd_back.
`default_nettype none
module point_extend_along_rotated_direction
   import perd_pkg::*;
#(
   parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
   parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [31:0] req_start_x, req_start_y, req_start_z,
   input  wire logic signed [31:0] req_end_x, req_end_y, req_end_z,
   input  wire logic signed [31:0] req_move_length,
   input  wire logic signed [15:0] req_angle_offset,
   output logic                    rsp_valid,
   output logic signed [COORD_WIDTH-1:0] rsp_new_x, rsp_new_y, rsp_new_z,
   output logic                    rsp_moved
);
   logic        f_valid, q_valid;
   item_type    f_item, q_item;
   logic [31:0] f_theta, q_theta;

   assign busy = 1'b0;

   perd_front #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_front (
      .clock, .reset, .in_valid(start),
      .sx(req_start_x), .sy(req_start_y), .sz(req_start_z),
      .ex(req_end_x), .ey(req_end_y), .ez(req_end_z),
      .len(req_move_length), .off(req_angle_offset),
      .out_valid(f_valid), .out_item(f_item), .out_theta(f_theta));

   perd_queue u_queue (
      .clock, .reset, .wr_valid(f_valid), .wr_item(f_item), .wr_theta(f_theta),
      .rd_valid(q_valid), .rd_item(q_item), .rd_theta(q_theta));

   perd_back #(.COORD_WIDTH(COORD_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_back (
      .clock, .reset, .in_valid(q_valid), .in_item(q_item), .in_theta(q_theta),
      .out_valid(rsp_valid), .new_x(rsp_new_x), .new_y(rsp_new_y),
      .new_z(rsp_new_z), .moved(rsp_moved));
endmodule
`default_nettype wire

FILE: test/perd_checker.sv
// Checker for the point extension block: predicts each result from the accepted
// request and compares it with the strobed response. Depends on perd_pkg only.
`default_nettype none
module perd_checker
   import perd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire logic signed [31:0] req_start_x, req_start_y, req_start_z,
   input  wire logic signed [31:0] req_end_x, req_end_y, req_end_z,
   input  wire logic signed [31:0] req_move_length,
   input  wire logic signed [15:0] req_angle_offset,
   input  wire logic               rsp_valid,
   input  wire logic signed [31:0] rsp_new_x, rsp_new_y, rsp_new_z,
   input  wire logic               rsp_moved,
   output int                      fail_count,
   output int                      pending,
   output int                      checked,
   output int                      still_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [31:0] nx;
      logic signed [31:0] ny;
      logic signed [31:0] nz;
      logic               mv;
   } point_result_type;

   localparam logic [31:0] ARCTAN [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
   localparam longint THRESH_Q30 = 64'sd10737418;
   localparam longint UNIT_GAIN = 64'sd652032874;
   localparam int NSTAGES = 16;

   point_result_type moved_points_q[$];

   // Round to the angle grid of 2^16 steps per turn.
   function automatic logic [31:0] snap_angle(input logic [31:0] a);
      return (a + 32'h0000_8000) & 32'hFFFF_0000;
   endfunction

   // Direction angle of (dx, dy) by vectoring iterations.
   function automatic logic [31:0] direction_of(input longint dx, input longint dy);
      longint x, y, m, t;
      logic [31:0] z;
      z = 0;
      if (dx == 0 && dy == 0) return 0;
      m = (dx < 0 ? -dx : dx) | (dy < 0 ? -dy : dy);
      x = dx;
      y = dy;
      while (m < (64'sd1 <<< 39)) begin
         m = m * 2;
         x = x * 2;
         y = y * 2;
      end
      if (x < 0) begin
         x = -x;
         y = -y;
         z = 32'h8000_0000;
      end
      for (int i = 0; i < NSTAGES; i++) begin
         t = x;
         if (y > 0) begin
            x = x + (y >>> i);
            y = y - (t >>> i);
            z = z + ARCTAN[i];
         end else begin
            x = x - (y >>> i);
            y = y + (t >>> i);
            z = z - ARCTAN[i];
         end
      end
      return z;
   endfunction

   // Cosine and sine in Q2.30 by rotation iterations.
   task automatic rotate_unit(input logic [31:0] theta, output longint c, output longint s);
      logic [1:0] quad;
      logic       flip;
      longint     x, y, z, t;
      quad = theta[31:30];
      flip = (quad == 2'd1 || quad == 2'd2);
      if (flip) theta = theta - 32'h8000_0000;
      z = longint'(signed'(theta));
      x = UNIT_GAIN;
      y = 0;
      for (int i = 0; i < NSTAGES; i++) begin
         t = x;
         if (z >= 0) begin
            x = x - (y >>> i);
            y = y + (t >>> i);
            z = z - longint'(ARCTAN[i]);
         end else begin
            x = x + (y >>> i);
            y = y - (t >>> i);
            z = z + longint'(ARCTAN[i]);
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   // Move one axis and clamp to the coordinate range.
   function automatic logic signed [31:0] shift_axis(input longint base, input longint len,
                                                     input longint comp);
      longint v;
      v = base;
      if ((comp < 0 ? -comp : comp) > THRESH_Q30)
         v = v + ((len * comp + (64'sd1 <<< 29)) >>> 30);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d want %0d (result %0d)", what, got, want, checked);
      fail_count++;
   endtask

   // Predict on each accepted transfer, compare on each strobe.
   always @(posedge clock) begin
      point_result_type p, r;
      logic [31:0] th;
      longint c, s;
      if (!reset && start && !busy) begin
         p.nz = req_end_z;
         if (req_start_x == req_end_x && req_start_y == req_end_y &&
             req_start_z == req_end_z) begin
            p.nx = req_end_x;
            p.ny = req_end_y;
            p.mv = 1'b0;
            still_count++;
         end else begin
            th = snap_angle(direction_of(longint'(req_end_x) - longint'(req_start_x),
                                         longint'(req_end_y) - longint'(req_start_y)));
            th = th + snap_angle({req_angle_offset, 16'h0});
            rotate_unit(th, c, s);
            p.nx = shift_axis(req_end_x, req_move_length, c);
            p.ny = shift_axis(req_end_y, req_move_length, s);
            p.mv = 1'b1;
         end
         moved_points_q.push_back(p);
      end
      if (!reset && rsp_valid) begin
         if (moved_points_q.size() == 0) begin
            report("result with nothing outstanding", 1, 0);
         end else begin
            r = moved_points_q.pop_front();
            if (rsp_new_x !== r.nx) report("new_x", rsp_new_x, r.nx);
            if (rsp_new_y !== r.ny) report("new_y", rsp_new_y, r.ny);
            if (rsp_new_z !== r.nz) report("new_z", rsp_new_z, r.nz);
            if (rsp_moved !== r.mv) report("moved", rsp_moved, r.mv);
         end
         checked++;
      end
      pending <= moved_points_q.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
      checked = 0;
      still_count = 0;
   end
endmodule
`default_nettype wire

FILE: test/tb.sv
// Testbench top for the point extension block: clock, reset, stimulus, verdict.
// Depends on perd_pkg, point_extend_along_rotated_direction and perd_checker.
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 16 * 2 + 9;
   localparam int RANDOM_ITEMS = 1700;
   localparam int CYCLE_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [31:0] req_start_x = '0, req_start_y = '0, req_start_z = '0;
   logic signed [31:0] req_end_x = '0, req_end_y = '0, req_end_z = '0;
   logic signed [31:0] req_move_length = '0;
   logic signed [15:0] req_angle_offset = '0;
   logic rsp_valid, rsp_moved;
   logic signed [31:0] rsp_new_x, rsp_new_y, rsp_new_z;
   int fail_count, pending, checked, still_count;
   int cycles = 0;

   point_extend_along_rotated_direction dut (.*);

   perd_checker chk (.*);

   always #10 clock = ~clock;

   // Stop a hung run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Hold one request on the ports until a transfer takes it.
   task automatic send_point(input logic [31:0] sx, sy, sz, ex, ey, ez, len,
                             input logic [15:0] off);
      req_start_x <= sx;
      req_start_y <= sy;
      req_start_z <= sz;
      req_end_x <= ex;
      req_end_y <= ey;
      req_end_z <= ez;
      req_move_length <= len;
      req_angle_offset <= off;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord(input int mode);
      case (mode)
         0: return $urandom();
         1: return $urandom_range(0, 4000) - 2000;
         2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 50)
                                       : 32'h8000_0000 + $urandom_range(0, 50);
         default: return $signed($urandom()) >>> $urandom_range(0, 31);
      endcase
   endfunction

   initial begin
      logic [31:0] sx, sy, sz, ex, ey, ez, len;
      int mode, burst;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: equal points, axis directions, extremes and offsets.
      send_point(0, 0, 0, 0, 0, 0, 256, 0);
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 5, 32'h7FFF_FFFF, 32'h8000_0000, 5, 9, 1);
      send_point(0, 0, 0, 0, 0, 7, 1000, 16'h4000);
      send_point(0, 0, 0, 0, 0, -7, 1000, 16'h8000);
      send_point(0, 0, 0, 256, 0, 0, 2560, 0);
      send_point(0, 0, 0, 0, 256, 0, 2560, 0);
      send_point(0, 0, 0, -256, 0, 0, 2560, 0);
      send_point(0, 0, 0, 0, -256, 0, 2560, 0);
      send_point(0, 0, 0, 256, 256, 0, 2560, 16'h2000);
      send_point(0, 0, 0, 100, 1, 0, 32'h7FFF_FFFF, 16'h7FFF);
      send_point(0, 0, 0, 32'h7FFF_FFF0, 0, 0, 32'h7FFF_FFFF, 0);
      send_point(0, 0, 0, 32'h8000_0010, 0, 0, 32'h7FFF_FFFF, 0);
      send_point(0, 0, 0, 0, 32'h8000_0000, 0, 32'h8000_0000, 0);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'h8000);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h8000_0000, 0,
                 32'hFFFF_FFFF, 16'hFFFF);
      send_point(0, 0, 0, 1000, 3, 0, 5000, 16'h3FFF);
      send_point(0, 0, 0, 1000, -3, 0, -5000, 16'hC001);
      send_point(0, 0, 0, 3, 1000, 0, 5000, 16'h0001);

      // Random: bursts of transfers with random gaps between some of them.
      for (int n = 0; n < RANDOM_ITEMS; ) begin
         burst = $urandom_range(1, 30);
         for (int b = 0; b < burst && n < RANDOM_ITEMS; b++, n++) begin
            mode = $urandom_range(0, 3);
            sx = rand_coord(mode);
            sy = rand_coord(mode);
            sz = rand_coord(mode);
            ex = rand_coord(mode);
            ey = rand_coord(mode);
            ez = rand_coord(mode);
            case ($urandom_range(0, 9))
               0: begin ex = sx; ey = sy; ez = sz; end
               1: begin ex = sx; ey = sy; end
               2: ex = sx;
               3: ey = sy;
               default: ;
            endcase
            len = $urandom_range(0, 1) ? $urandom() : rand_coord(mode);
            send_point(sx, sy, sz, ex, ey, ez, len, 16'($urandom()));
         end
         if ($urandom_range(0, 2) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      start <= 1'b0;

      // Drain the pipeline.
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      $display("Checked %0d results, %0d of them with coincident points.",
               checked, still_count);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
`default_nettype wire
